>>> hw/rtl/spq_pkg.sv
// Shared types and codes for the stable priority queue.
// No dependencies; used by stable_priority_queue_core.
`default_nettype none

package spq_pkg;

  localparam int DEPTH    = 16;
  localparam int PRIO_W   = 8;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = $clog2(DEPTH + 1);

  // op field
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // status field
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

endpackage : spq_pkg

`default_nettype wire

>>> hw/rtl/stable_priority_queue_core.sv
// Stable priority queue: sorted circular buffer in one synchronous RAM; depends on spq_pkg.
// A refusal or an enqueue into an empty queue goes from S_IDLE to S_RESP; a dequeue via S_DEQ;
// any other enqueue via S_SCAN (then S_PLACE if all stored entries move), where each stored
// entry of lower priority moves back one slot per cycle through the single RAM read/write port
// pair. One beat in flight; the next beat is accepted in the cycle after its result is loaded.
// Reset (rst_n, synchronous) empties the queue; RAM contents are left as they are.
`default_nettype none

module stable_priority_queue_core (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire                             in_op,
  input  wire  [spq_pkg::PRIO_W-1:0]      in_priority_req,
  input  wire  [spq_pkg::TAG_W-1:0]       in_payload_tag,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [spq_pkg::STATUS_W-1:0]    out_status,
  output logic [spq_pkg::PRIO_W-1:0]      out_priority,
  output logic [spq_pkg::TAG_W-1:0]       out_tag,
  output logic [spq_pkg::OCC_W-1:0]       out_occupancy
);

  localparam int DEPTH = spq_pkg::DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int OccW  = spq_pkg::OCC_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN,
    S_PLACE,
    S_RESP
  } state_t;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
    ptr_inc = (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] a);
    ptr_dec = (a == '0) ? AW'(DEPTH - 1) : a - 1'b1;
  endfunction

  state_t                        state_r;
  logic [AW-1:0]                 head_r, tail_r, pos_r;
  logic [CW-1:0]                 count_r, left_r;
  spq_pkg::entry_t               new_r;
  spq_pkg::entry_t               rdata_r;
  logic [spq_pkg::STATUS_W-1:0]  res_status_r;
  spq_pkg::entry_t               res_entry_r;
  logic [OccW-1:0]               res_occ_r;
  logic                          out_valid_r;
  logic [spq_pkg::STATUS_W-1:0]  out_status_r;
  spq_pkg::entry_t               out_entry_r;
  logic [OccW-1:0]               out_occ_r;

  spq_pkg::entry_t               mem [DEPTH];

  logic                          in_fire;
  logic                          out_load;
  logic                          q_full, q_empty;
  spq_pkg::entry_t               in_entry;
  logic [AW-1:0]                 pos_dn;
  logic                          shift_up;
  logic                          mem_re, mem_we;
  logic [AW-1:0]                 mem_ra, mem_wa;
  spq_pkg::entry_t               mem_wd;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign out_load = (state_r == S_RESP) && (!out_valid_r || out_ready);
  assign q_full   = (count_r == CW'(DEPTH));
  assign q_empty  = (count_r == '0);
  assign in_entry = '{prio: in_priority_req, tag: in_payload_tag};
  assign pos_dn   = ptr_dec(pos_r);
  // stored entry moves back only if strictly lower priority: keeps arrival order
  assign shift_up = (rdata_r.prio < new_r.prio);

  always_comb begin
    mem_re = 1'b0;
    mem_ra = '0;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = new_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_op == spq_pkg::OP_DEQ) begin
            mem_re = ~q_empty;
            mem_ra = head_r;
          end else if (!q_full) begin
            if (q_empty) begin
              mem_we = 1'b1;
              mem_wa = tail_r;
              mem_wd = in_entry;
            end else begin
              mem_re = 1'b1;
              mem_ra = ptr_dec(tail_r);
            end
          end
        end
      end
      S_SCAN: begin
        mem_we = 1'b1;
        mem_wa = pos_r;
        if (shift_up) begin
          mem_wd = rdata_r;
          mem_re = (left_r != CW'(1));
          mem_ra = ptr_dec(pos_dn);
        end
      end
      S_PLACE: begin
        mem_we = 1'b1;
        mem_wa = pos_r;
      end
      S_DEQ, S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            new_r       <= in_entry;
            res_entry_r <= '0;
            pos_r       <= tail_r;
            left_r      <= count_r;
            if (in_op == spq_pkg::OP_DEQ) begin
              res_occ_r <= OccW'(count_r);
              if (q_empty) begin
                res_status_r <= spq_pkg::STATUS_EMPTY;
                state_r      <= S_RESP;
              end else begin
                res_status_r <= spq_pkg::STATUS_OK;
                state_r      <= S_DEQ;
              end
            end else if (q_full) begin
              res_occ_r    <= OccW'(count_r);
              res_status_r <= spq_pkg::STATUS_FULL;
              state_r      <= S_RESP;
            end else if (q_empty) begin
              res_status_r <= spq_pkg::STATUS_OK;
              tail_r       <= ptr_inc(tail_r);
              count_r      <= count_r + 1'b1;
              res_occ_r    <= OccW'(count_r + 1'b1);
              state_r      <= S_RESP;
            end else begin
              res_status_r <= spq_pkg::STATUS_OK;
              res_occ_r    <= OccW'(count_r);
              state_r      <= S_SCAN;
            end
          end
        end
        S_DEQ: begin
          res_entry_r <= rdata_r;
          head_r      <= ptr_inc(head_r);
          count_r     <= count_r - 1'b1;
          res_occ_r   <= OccW'(count_r - 1'b1);
          state_r     <= S_RESP;
        end
        S_SCAN: begin
          if (shift_up) begin
            pos_r  <= pos_dn;
            left_r <= left_r - 1'b1;
            if (left_r == CW'(1)) begin
              state_r <= S_PLACE;
            end
          end else begin
            tail_r    <= ptr_inc(tail_r);
            count_r   <= count_r + 1'b1;
            res_occ_r <= OccW'(count_r + 1'b1);
            state_r   <= S_RESP;
          end
        end
        S_PLACE: begin
          tail_r    <= ptr_inc(tail_r);
          count_r   <= count_r + 1'b1;
          res_occ_r <= OccW'(count_r + 1'b1);
          state_r   <= S_RESP;
        end
        S_RESP: begin
          if (out_load) begin
            out_status_r <= res_status_r;
            out_entry_r  <= res_entry_r;
            out_occ_r    <= res_occ_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_priority  = out_entry_r.prio;
  assign out_tag       = out_entry_r.tag;
  assign out_occupancy = out_occ_r;

endmodule : stable_priority_queue_core

`default_nettype wire
